// ----- hdl/multi_pattern_byte_matcher_assert.svh -----
// Assertion macros used by the matcher controller RTL.
`ifndef MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define MPBM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define MPBM_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- hdl/mpbm_pkg.sv -----
// Package: widths, op codes and shared types of the matcher.
`default_nettype none
package mpbm_pkg;
    localparam int MAX_NODES     = 256;
    localparam int MAX_PATTERNS  = 16;
    localparam int POSITION_BITS = 32;
    localparam int NODE_BITS     = 8;
    localparam int NC_BITS       = 9;
    localparam int PC_BITS       = 5;
    localparam int PIDX_BITS     = 4;
    localparam int GOTO_BITS     = NODE_BITS + 8;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_PBYTE = 3'd1;
    localparam logic [2:0] OP_PEND  = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_TEXT  = 3'd4;

    localparam logic KIND_MATCH    = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    // One trie node: its incoming edge, depth, masks and fail link
    typedef struct packed {
        logic [NODE_BITS-1:0]    par;
        logic [7:0]              pbyte;
        logic [NODE_BITS-1:0]    depth;
        logic [MAX_PATTERNS-1:0] own;
        logic [NODE_BITS-1:0]    fail;
        logic [MAX_PATTERNS-1:0] full;
    } t_node;

    // Access requests from the controller to the two memories
    typedef struct packed {
        logic                 g_we;
        logic [GOTO_BITS-1:0] g_waddr;
        logic [NODE_BITS-1:0] g_wdata;
        logic [GOTO_BITS-1:0] g_raddr;
        logic                 n_we;
        logic [NODE_BITS-1:0] n_waddr;
        t_node                n_wdata;
        logic [NODE_BITS-1:0] n_raddr;
    } t_mem_req;
endpackage
`default_nettype wire

// ----- hdl/mpbm_if.sv -----
// Channel interfaces: input items and result items.
`default_nettype none
interface mpbm_in_if import mpbm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] data_byte;
    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface mpbm_out_if import mpbm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [31:0]              match_position;
    logic [PIDX_BITS-1:0]     pattern_index;
    logic                     last;
    modport source (output valid, output kind, output match_position,
                    output pattern_index, output last, input ready);
    modport sink   (input valid, input kind, input match_position,
                    input pattern_index, input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/mpbm_store.sv -----
// Goto edge memory and node memory, both with registered reads.
`default_nettype none
module mpbm_store import mpbm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire t_mem_req             i_req,
    output logic [NODE_BITS-1:0]      o_g_q,
    output t_node                     o_n_q
);
    logic [NODE_BITS-1:0] r_goto [1 << GOTO_BITS];
    t_node                r_node [MAX_NODES];

    // goto edges: node per (node, byte)
    always_ff @(posedge i_clk) begin
        if (i_req.g_we) begin
            r_goto[i_req.g_waddr] <= i_req.g_wdata;
        end
        o_g_q <= r_goto[i_req.g_raddr];
    end

    // per-node record
    always_ff @(posedge i_clk) begin
        if (i_req.n_we) begin
            r_node[i_req.n_waddr] <= i_req.n_wdata;
        end
        o_n_q <= r_node[i_req.n_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/mpbm_ctrl.sv -----
// Sequencer: trie insertion, fail-link build, text walk and result output.
`default_nettype none
`include "multi_pattern_byte_matcher_assert.svh"
module mpbm_ctrl import mpbm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [2:0]           i_op,
    input  wire logic [7:0]           i_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_kind,
    output logic [31:0]               o_pos,
    output logic [PIDX_BITS-1:0]      o_idx,
    output logic                      o_last,
    output t_mem_req                  o_mem,
    input  wire logic [NODE_BITS-1:0] i_g_q,
    input  wire t_node                i_n_q
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LA    = 5'd1;
    localparam logic [4:0] S_LB    = 5'd2;
    localparam logic [4:0] S_LC    = 5'd3;
    localparam logic [4:0] S_LF    = 5'd4;
    localparam logic [4:0] S_LF2   = 5'd5;
    localparam logic [4:0] S_TM    = 5'd6;
    localparam logic [4:0] S_TM2   = 5'd7;
    localparam logic [4:0] S_EMIT  = 5'd8;
    localparam logic [4:0] S_OVF   = 5'd9;
    localparam logic [4:0] S_PW    = 5'd10;
    localparam logic [4:0] S_ER    = 5'd11;
    localparam logic [4:0] S_EW    = 5'd12;
    localparam logic [4:0] S_BST   = 5'd13;
    localparam logic [4:0] S_BRD   = 5'd14;
    localparam logic [4:0] S_BCHK  = 5'd15;
    localparam logic [4:0] S_BPF   = 5'd16;
    localparam logic [4:0] S_BPF2  = 5'd17;
    localparam logic [4:0] S_BFIN  = 5'd18;
    localparam logic [4:0] S_BFIN2 = 5'd19;
    localparam logic [4:0] S_BNXT  = 5'd20;
    localparam logic [4:0] S_BDONE = 5'd21;

    localparam logic [1:0] MODE_PAT   = 2'd0;
    localparam logic [1:0] MODE_TEXT  = 2'd1;
    localparam logic [1:0] MODE_BUILD = 2'd2;

    logic [4:0]                r_st;
    logic [1:0]                r_mode;
    logic [NC_BITS-1:0]        r_nc;
    logic [PC_BITS-1:0]        r_pc;
    logic [NODE_BITS-1:0]      r_cursor;
    logic [7:0]                r_curlen;
    logic                      r_built;
    logic                      r_drop;
    logic [NODE_BITS-1:0]      r_mstate;
    logic [POSITION_BITS-1:0]  r_pos;
    logic [MAX_PATTERNS-1:0]   r_root_own;
    logic [MAX_PATTERNS-1:0]   r_root_full;
    logic [NODE_BITS-1:0]      r_maxd;
    logic [7:0]                r_len [MAX_PATTERNS];
    logic [NODE_BITS-1:0]      r_cur;
    logic [7:0]                r_byte;
    logic [7:0]                r_tbyte;
    logic [NODE_BITS-1:0]      r_bd;
    logic [NODE_BITS-1:0]      r_bc;
    logic [NODE_BITS-1:0]      r_fl;
    t_node                     r_word;
    logic [MAX_PATTERNS-1:0]   r_mask;
    logic [MAX_PATTERNS-1:0]   r_ebit;
    logic                      r_ovalid;
    logic                      r_okind;
    logic [31:0]               r_opos;
    logic [PIDX_BITS-1:0]      r_oidx;
    logic                      r_olast;

    logic                      w_in_fire;
    logic                      w_out_free;
    logic                      w_edge_ok;
    logic                      w_pat_full;
    logic [PIDX_BITS-1:0]      w_pidx;
    logic [MAX_PATTERNS-1:0]   w_rest;
    logic [MAX_PATTERNS-1:0]   w_pbit;
    logic [MAX_PATTERNS-1:0]   w_full_fl;
    logic [POSITION_BITS-1:0]  w_mpos;
    t_node                     w_new;

    assign o_in_ready  = (r_st == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_ovalid || i_out_ready;
    assign w_pat_full  = (r_pc >= PC_BITS'(MAX_PATTERNS));
    assign w_pbit      = MAX_PATTERNS'(1) << r_pc[PIDX_BITS-1:0];
    assign w_full_fl   = (r_fl == '0) ? r_root_full : i_n_q.full;

    // stored edge is live only if its child was allocated from this node and byte
    assign w_edge_ok = (i_g_q != '0) && ({1'b0, i_g_q} < r_nc)
                       && (i_n_q.par == r_cur) && (i_n_q.pbyte == r_byte);

    // lowest pending pattern of the match mask
    always_comb begin
        w_pidx = '0;
        for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
            if (r_mask[i]) w_pidx = PIDX_BITS'(i);
        end
        w_rest = r_mask & ~(MAX_PATTERNS'(1) << w_pidx);
    end

    assign w_mpos = r_pos - POSITION_BITS'(r_len[w_pidx]) + POSITION_BITS'(1);

    // record of a freshly allocated node
    always_comb begin
        w_new       = '0;
        w_new.par   = r_cursor;
        w_new.pbyte = r_byte;
        w_new.depth = r_curlen + 8'd1;
    end

    // memory requests
    always_comb begin
        o_mem         = '0;
        o_mem.g_raddr = {r_cur, r_byte};
        o_mem.g_waddr = {r_cursor, r_byte};
        o_mem.g_wdata = r_nc[NODE_BITS-1:0];
        o_mem.n_waddr = r_cur;
        o_mem.n_wdata = i_n_q;
        unique case (r_st)
            S_LB:    o_mem.n_raddr = i_g_q;
            S_BRD:   o_mem.n_raddr = r_bc;
            S_BPF:   o_mem.n_raddr = r_word.par;
            S_BFIN:  o_mem.n_raddr = r_fl;
            default: o_mem.n_raddr = r_cur;
        endcase
        unique case (r_st)
            S_PW: begin
                o_mem.g_we    = 1'b1;
                o_mem.n_we    = 1'b1;
                o_mem.n_waddr = r_nc[NODE_BITS-1:0];
                o_mem.n_wdata = w_new;
            end
            S_EW: begin
                o_mem.n_we        = 1'b1;
                o_mem.n_wdata.own = i_n_q.own | r_ebit;
            end
            S_BFIN2: begin
                o_mem.n_we         = 1'b1;
                o_mem.n_waddr      = r_bc;
                o_mem.n_wdata      = r_word;
                o_mem.n_wdata.fail = r_fl;
                o_mem.n_wdata.full = r_word.own | w_full_fl;
            end
            default: ;
        endcase
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_mode     <= MODE_PAT;
            r_nc       <= NC_BITS'(1);
            r_pc       <= '0;
            r_cursor   <= '0;
            r_curlen   <= '0;
            r_built    <= 1'b0;
            r_drop     <= 1'b0;
            r_mstate   <= '0;
            r_pos      <= '0;
            r_root_own <= '0;
            r_maxd     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_out_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (w_in_fire) begin
                        case (i_op)
                            OP_CLEAR: begin
                                r_nc       <= NC_BITS'(1);
                                r_pc       <= '0;
                                r_cursor   <= '0;
                                r_curlen   <= '0;
                                r_built    <= 1'b0;
                                r_drop     <= 1'b0;
                                r_mstate   <= '0;
                                r_root_own <= '0;
                                r_maxd     <= '0;
                            end
                            OP_PBYTE: begin
                                r_built <= 1'b0;
                                if (!r_drop) begin
                                    if (w_pat_full) begin
                                        r_drop <= 1'b1;
                                    end else begin
                                        r_cur  <= r_cursor;
                                        r_byte <= i_data;
                                        r_mode <= MODE_PAT;
                                        r_st   <= S_LA;
                                    end
                                end
                            end
                            OP_PEND: begin
                                if (!(r_drop || w_pat_full)) begin
                                    if (r_cursor == '0) begin
                                        r_root_own <= r_root_own | w_pbit;
                                    end else begin
                                        r_cur  <= r_cursor;
                                        r_ebit <= w_pbit;
                                        r_st   <= S_ER;
                                    end
                                    r_len[r_pc[PIDX_BITS-1:0]] <= r_curlen;
                                    r_pc    <= r_pc + PC_BITS'(1);
                                    r_built <= 1'b0;
                                end else begin
                                    r_st <= S_OVF;
                                end
                                r_cursor <= '0;
                                r_curlen <= '0;
                                r_drop   <= 1'b0;
                            end
                            OP_START: begin
                                r_mstate <= '0;
                                r_pos    <= '0;
                            end
                            OP_TEXT: begin
                                r_tbyte <= i_data;
                                if (r_built) begin
                                    r_cur  <= r_mstate;
                                    r_byte <= i_data;
                                    r_mode <= MODE_TEXT;
                                    r_st   <= S_LA;
                                end else begin
                                    r_st <= S_BST;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // edge lookup: goto read, then check of the child's record
                S_LA: r_st <= S_LB;
                S_LB: r_st <= S_LC;
                S_LC: begin
                    unique case (r_mode)
                        MODE_PAT: begin
                            if (w_edge_ok) begin
                                r_cursor <= i_g_q;
                                r_curlen <= r_curlen + 8'd1;
                                r_st     <= S_IDLE;
                            end else if (r_nc >= NC_BITS'(MAX_NODES)) begin
                                r_drop <= 1'b1;
                                r_st   <= S_IDLE;
                            end else begin
                                r_st <= S_PW;
                            end
                        end
                        MODE_TEXT: begin
                            if (w_edge_ok) begin
                                r_cur <= i_g_q;
                                r_st  <= S_TM;
                            end else if (r_cur == '0) begin
                                r_st <= S_TM;
                            end else begin
                                r_st <= S_LF;
                            end
                        end
                        default: begin
                            if (w_edge_ok) begin
                                r_fl <= (i_g_q != r_bc) ? i_g_q : '0;
                                r_st <= S_BFIN;
                            end else if (r_cur == '0) begin
                                r_fl <= '0;
                                r_st <= S_BFIN;
                            end else begin
                                r_st <= S_LF;
                            end
                        end
                    endcase
                end
                // follow one fail link
                S_LF:  r_st <= S_LF2;
                S_LF2: begin
                    r_cur <= i_n_q.fail;
                    r_st  <= S_LA;
                end
                S_TM: begin
                    r_mstate <= r_cur;
                    r_st     <= S_TM2;
                end
                S_TM2: begin
                    r_mask <= (r_cur == '0) ? r_root_full : i_n_q.full;
                    r_st   <= S_EMIT;
                end
                // one result per cycle while the output is free, ascending pattern index
                S_EMIT: begin
                    if (r_mask == '0) begin
                        r_pos <= r_pos + POSITION_BITS'(1);
                        r_st  <= S_IDLE;
                    end else if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_MATCH;
                        r_opos   <= 32'(w_mpos);
                        r_oidx   <= w_pidx;
                        r_olast  <= (w_rest == '0);
                        r_mask   <= w_rest;
                        if (w_rest == '0) begin
                            r_pos <= r_pos + POSITION_BITS'(1);
                            r_st  <= S_IDLE;
                        end
                    end
                end
                S_OVF: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_OVERFLOW;
                        r_opos   <= '0;
                        r_oidx   <= '0;
                        r_olast  <= 1'b1;
                        r_st     <= S_IDLE;
                    end
                end
                // new node written in both memories
                S_PW: begin
                    r_cursor <= r_nc[NODE_BITS-1:0];
                    r_curlen <= r_curlen + 8'd1;
                    r_nc     <= r_nc + NC_BITS'(1);
                    if (r_curlen + 8'd1 > r_maxd) r_maxd <= r_curlen + 8'd1;
                    r_st     <= S_IDLE;
                end
                S_ER: r_st <= S_EW;
                S_EW: r_st <= S_IDLE;
                // fail-link build, level by level
                S_BST: begin
                    r_root_full <= r_root_own;
                    r_bd        <= NODE_BITS'(1);
                    r_bc        <= NODE_BITS'(1);
                    r_mode      <= MODE_BUILD;
                    r_st        <= (r_nc == NC_BITS'(1)) ? S_BDONE : S_BRD;
                end
                S_BRD: r_st <= S_BCHK;
                S_BCHK: begin
                    r_word <= i_n_q;
                    if (i_n_q.depth != r_bd) begin
                        r_st <= S_BNXT;
                    end else if (i_n_q.par == '0) begin
                        r_fl <= '0;
                        r_st <= S_BFIN;
                    end else begin
                        r_byte <= i_n_q.pbyte;
                        r_st   <= S_BPF;
                    end
                end
                S_BPF:  r_st <= S_BPF2;
                S_BPF2: begin
                    r_cur <= i_n_q.fail;
                    r_st  <= S_LA;
                end
                S_BFIN:  r_st <= S_BFIN2;
                S_BFIN2: r_st <= S_BNXT;
                S_BNXT: begin
                    if ({1'b0, r_bc} + NC_BITS'(1) == r_nc) begin
                        if (r_bd >= r_maxd) begin
                            r_st <= S_BDONE;
                        end else begin
                            r_bd <= r_bd + NODE_BITS'(1);
                            r_bc <= NODE_BITS'(1);
                            r_st <= S_BRD;
                        end
                    end else begin
                        r_bc <= r_bc + NODE_BITS'(1);
                        r_st <= S_BRD;
                    end
                end
                S_BDONE: begin
                    r_built <= 1'b1;
                    r_cur   <= r_mstate;
                    r_byte  <= r_tbyte;
                    r_mode  <= MODE_TEXT;
                    r_st    <= S_LA;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_pos       = r_opos;
    assign o_idx       = r_oidx;
    assign o_last      = r_olast;

    `MPBM_ASSERT_ALWAYS(a_nc_range, (r_nc >= NC_BITS'(1)) && (r_nc <= NC_BITS'(MAX_NODES)), "node count out of range")
    `MPBM_ASSERT_ALWAYS(a_pc_range, r_pc <= PC_BITS'(MAX_PATTERNS), "pattern count out of range")
    `MPBM_ASSERT_ALWAYS(a_nodes_live, ({1'b0, r_cursor} < r_nc) && ({1'b0, r_mstate} < r_nc), "cursor or match state beyond allocated nodes")
    `MPBM_ASSERT_NEXT(a_clear, w_in_fire && (i_op == OP_CLEAR), (r_nc == NC_BITS'(1)) && (r_pc == '0) && !r_built, "clear did not empty the set")
endmodule
`default_nettype wire

// ----- hdl/multi_pattern_byte_matcher.sv -----
// Top level of the multi-pattern byte matcher.
//  channel | dir | signals                                           | transfer when
//  i_in    | in  | op, data_byte                                     | valid && ready
//  o_out   | out | kind, match_position, pattern_index, last         | valid && ready
// Pattern byte: edge lookup (edge read, child record read, check), then a node write
// when a node is added; no lookup once the pattern is dropped. End sets the end bit
// or gives an overflow result; start resets the text walk. Text byte: edge lookup,
// repeated per fail link followed, then the mask read, then one result per cycle
// while the output is free. A text byte after a change to the pattern set first runs
// the fail-link build: one scan of the non-root nodes per depth level, each node at
// that depth getting a fail-link search. A stalled output holds the sequencer.
// Reset is synchronous and empties the pattern set.
`default_nettype none
module multi_pattern_byte_matcher import mpbm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mpbm_in_if.sink    i_in,
    mpbm_out_if.source o_out
);
    t_mem_req             w_mem;
    logic [NODE_BITS-1:0] w_g_q;
    t_node                w_n_q;

    // control and output register
    mpbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .i_data      (i_in.data_byte),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_kind      (o_out.kind),
        .o_pos       (o_out.match_position),
        .o_idx       (o_out.pattern_index),
        .o_last      (o_out.last),
        .o_mem       (w_mem),
        .i_g_q       (w_g_q),
        .i_n_q       (w_n_q)
    );

    // trie memories
    mpbm_store u_store (
        .i_clk (i_clk),
        .i_req (w_mem),
        .o_g_q (w_g_q),
        .o_n_q (w_n_q)
    );
endmodule
`default_nettype wire
